// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/dfa_pkg.sv =====
// Types, constants and tables of the flip-angle map pipeline
`default_nettype none
package dfa_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int ANGLE_FRAC      = 16;
  localparam int CORDIC_STEPS    = 23;
  localparam int SQRT_STEPS      = 32;
  localparam int NORM_STAGES     = 6;
  localparam int XY_W            = 35;
  localparam int Z_W             = 25;
  localparam int OUT_W           = 15;
  localparam int REM_W           = 35;
  localparam int LANE_Y          = 0;
  localparam int LANE_X          = 1;
  localparam int RIGHT_ANGLE_Q16 = 90 * 65536;
  localparam logic [OUT_W-1:0] RIGHT_ANGLE_OUT = OUT_W'(23040);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ste_re;
    logic signed [SAMPLE_W-1:0] ste_im;
    logic signed [SAMPLE_W-1:0] fid_re;
    logic signed [SAMPLE_W-1:0] fid_im;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] flip_angle;
    logic             fid_zero;
  } out_t;

  typedef enum logic [1:0] {
    KIND_CORDIC = 2'd0,
    KIND_FID_ZERO = 2'd1,
    KIND_ZERO = 2'd2,
    KIND_RIGHT = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] a;
    logic [63:0] b;
  } norm_st_t;

  typedef struct packed {
    logic [63:0]      n;
    logic [REM_W-1:0] rem;
    logic [31:0]      root;
  } root_lane_t;

  typedef struct packed {
    tag_t                  tag;
    root_lane_t [1:0]      lane;
  } sqrt_st_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_st_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dfa_norm_cell.sv =====
// Normalizer cell: shifts both operands left by SHIFT when their top bits are clear
`default_nettype none
module dfa_norm_cell #(
  parameter int SHIFT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  dfa_pkg::norm_st_t st_in,
  output dfa_pkg::norm_st_t st_out
);

  dfa_pkg::norm_st_t st_r, st_nxt;
  logic [63:0] m;

  always_comb begin
    m = st_in.a | st_in.b;
    st_nxt = st_in;
    if (m[63 -: SHIFT] == {SHIFT{1'b0}}) begin
      st_nxt.a = st_in.a << SHIFT;
      st_nxt.b = st_in.b << SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tag.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dfa_sqrt_cell.sv =====
// Square-root cell: one result bit of two restoring square roots
`default_nettype none
module dfa_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  dfa_pkg::sqrt_st_t st_in,
  output dfa_pkg::sqrt_st_t st_out
);

  dfa_pkg::sqrt_st_t st_r, st_nxt;
  logic [1:0][dfa_pkg::REM_W-1:0] rs;
  logic [1:0][dfa_pkg::REM_W-1:0] trial;
  logic [1:0] ge;

  always_comb begin
    st_nxt = st_in;
    for (int l = 0; l < 2; l++) begin
      rs[l]    = {st_in.lane[l].rem[dfa_pkg::REM_W-3:0], st_in.lane[l].n[63:62]};
      trial[l] = {1'b0, st_in.lane[l].root, 2'b01};
      ge[l]    = rs[l] >= trial[l];
      st_nxt.lane[l].n    = {st_in.lane[l].n[61:0], 2'b00};
      st_nxt.lane[l].rem  = ge[l] ? rs[l] - trial[l] : rs[l];
      st_nxt.lane[l].root = {st_in.lane[l].root[30:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tag.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dfa_cordic_cell.sv =====
// Vectoring CORDIC cell: one micro-rotation toward the x axis
`default_nettype none
module dfa_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  dfa_pkg::cordic_st_t st_in,
  output dfa_pkg::cordic_st_t st_out
);

  dfa_pkg::cordic_st_t st_r, st_nxt;
  logic signed [dfa_pkg::XY_W-1:0] xs, ys;
  logic signed [dfa_pkg::Z_W-1:0]  ang;
  logic y_pos;

  always_comb begin
    xs     = st_in.x >>> STEP;
    ys     = st_in.y >>> STEP;
    ang    = dfa_pkg::atan_q16(STEP);
    y_pos  = !st_in.y[dfa_pkg::XY_W-1] && (st_in.y != '0);
    st_nxt = st_in;
    if (y_pos) begin
      st_nxt.x = st_in.x + ys;
      st_nxt.y = st_in.y - xs;
      st_nxt.z = st_in.z + ang;
    end else begin
      st_nxt.x = st_in.x - ys;
      st_nxt.y = st_in.y + xs;
      st_nxt.z = st_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tag.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dream_flip_angle_map.sv =====
// Top level of the DREAM flip-angle map pipeline
// Fully pipelined: one voxel transfer per cycle while in_ready is high; each result passes through
// (abs, square, sum and classify, 6 normalizer cells, 64 square-root cells for the two
// chained roots, 23 CORDIC cells, then the output buffer). A two-entry output buffer lets
// the pipeline keep moving while one result waits; in_ready drops only when both entries
// are full, which stalls every cell at once.
`default_nettype none
module dream_flip_angle_map (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dfa_pkg::out_t out_data
);

  `include "assert_macros.svh"

  localparam int W  = dfa_pkg::SAMPLE_W;
  localparam int NS = 2 * dfa_pkg::SQRT_STEPS;

  logic en;

  // abs stage
  logic            s1_valid_r;
  logic [3:0][W-1:0] mag_r;
  logic [3:0][W-1:0] mag_nxt;
  // square stage
  logic              s2_valid_r;
  logic [3:0][2*W-1:0] sq_r;
  // sum and classify
  logic [2*W:0] s2_sum, f2_sum;
  logic [63:0]  s2_64, f2_64, a_c, b_c;
  dfa_pkg::kind_t kind_c;

  dfa_pkg::norm_st_t   norm_st [dfa_pkg::NORM_STAGES+1];
  dfa_pkg::sqrt_st_t   sq_st   [NS+1];
  dfa_pkg::sqrt_st_t   sq_in   [NS];
  dfa_pkg::cordic_st_t co_st   [dfa_pkg::CORDIC_STEPS+1];

  // output buffer
  logic [1:0]    cnt_r, cnt_nxt;
  dfa_pkg::out_t buf0_r, buf0_nxt, buf1_r, buf1_nxt;
  dfa_pkg::out_t res;
  logic          push, pop;
  logic signed [dfa_pkg::Z_W-1:0] zl;
  logic [22:0] zc;
  logic [23:0] zr;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  always_comb begin
    mag_nxt[0] = in_data.ste_re[W-1] ? W'(~in_data.ste_re + 1'b1) : in_data.ste_re;
    mag_nxt[1] = in_data.ste_im[W-1] ? W'(~in_data.ste_im + 1'b1) : in_data.ste_im;
    mag_nxt[2] = in_data.fid_re[W-1] ? W'(~in_data.fid_re + 1'b1) : in_data.fid_re;
    mag_nxt[3] = in_data.fid_im[W-1] ? W'(~in_data.fid_im + 1'b1) : in_data.fid_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      mag_r      <= mag_nxt;
      s2_valid_r <= s1_valid_r;
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= mag_r[k] * mag_r[k];
      end
    end
  end

  always_comb begin
    s2_sum = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    f2_sum = {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
    s2_64  = 64'(s2_sum);
    f2_64  = 64'(f2_sum);
    if (s2_64[63:62] == 2'b00) begin
      a_c = s2_64 << 2;
      b_c = f2_64;
    end else begin
      a_c = s2_64;
      b_c = f2_64 >> 2;
    end
    if (f2_64 == '0) begin
      kind_c = dfa_pkg::KIND_FID_ZERO;
    end else if (s2_64 == '0) begin
      kind_c = dfa_pkg::KIND_ZERO;
    end else if (b_c == '0) begin
      kind_c = dfa_pkg::KIND_RIGHT;
    end else begin
      kind_c = dfa_pkg::KIND_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_st[0].tag.valid <= 1'b0;
    end else if (en) begin
      norm_st[0].tag.valid <= s2_valid_r;
      norm_st[0].tag.kind  <= kind_c;
      norm_st[0].a         <= a_c;
      norm_st[0].b         <= b_c;
    end
  end

  for (genvar k = 0; k < dfa_pkg::NORM_STAGES; k++) begin : g_norm
    dfa_norm_cell #(.SHIFT(32 >> k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .st_in  (norm_st[k]),
      .st_out (norm_st[k+1])
    );
  end

  always_comb begin
    sq_st[0].tag = norm_st[dfa_pkg::NORM_STAGES].tag;
    sq_st[0].lane[dfa_pkg::LANE_Y] = '{n: norm_st[dfa_pkg::NORM_STAGES].a, rem: '0, root: '0};
    sq_st[0].lane[dfa_pkg::LANE_X] = '{n: norm_st[dfa_pkg::NORM_STAGES].b, rem: '0, root: '0};
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    if (k == dfa_pkg::SQRT_STEPS) begin : g_reseed
      always_comb begin
        sq_in[k].tag = sq_st[k].tag;
        for (int l = 0; l < 2; l++) begin
          sq_in[k].lane[l].n    = {sq_st[k].lane[l].root, 32'b0};
          sq_in[k].lane[l].rem  = '0;
          sq_in[k].lane[l].root = '0;
        end
      end
    end else begin : g_pass
      assign sq_in[k] = sq_st[k];
    end
    dfa_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .st_in  (sq_in[k]),
      .st_out (sq_st[k+1])
    );
  end

  always_comb begin
    co_st[0].tag = sq_st[NS].tag;
    co_st[0].x   = dfa_pkg::XY_W'(sq_st[NS].lane[dfa_pkg::LANE_X].root);
    co_st[0].y   = dfa_pkg::XY_W'(sq_st[NS].lane[dfa_pkg::LANE_Y].root);
    co_st[0].z   = '0;
    if (sq_st[NS].tag.kind == dfa_pkg::KIND_CORDIC) begin
      if (sq_st[NS].lane[dfa_pkg::LANE_Y].root == '0) begin
        co_st[0].tag.kind = dfa_pkg::KIND_ZERO;
      end else if (sq_st[NS].lane[dfa_pkg::LANE_X].root == '0) begin
        co_st[0].tag.kind = dfa_pkg::KIND_RIGHT;
      end
    end
  end

  for (genvar k = 0; k < dfa_pkg::CORDIC_STEPS; k++) begin : g_cordic
    dfa_cordic_cell #(.STEP(k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .st_in  (co_st[k]),
      .st_out (co_st[k+1])
    );
  end

  // clamp, round and select the result
  always_comb begin
    zl = co_st[dfa_pkg::CORDIC_STEPS].z;
    if (zl[dfa_pkg::Z_W-1]) begin
      zc = '0;
    end else if (zl > dfa_pkg::Z_W'(dfa_pkg::RIGHT_ANGLE_Q16)) begin
      zc = 23'(dfa_pkg::RIGHT_ANGLE_Q16);
    end else begin
      zc = zl[22:0];
    end
    zr = {1'b0, zc} + 24'(1 << (dfa_pkg::ANGLE_FRAC - 9));
    res.fid_zero = 1'b0;
    case (co_st[dfa_pkg::CORDIC_STEPS].tag.kind)
      dfa_pkg::KIND_FID_ZERO: begin
        res.flip_angle = dfa_pkg::RIGHT_ANGLE_OUT;
        res.fid_zero   = 1'b1;
      end
      dfa_pkg::KIND_ZERO:  res.flip_angle = '0;
      dfa_pkg::KIND_RIGHT: res.flip_angle = dfa_pkg::RIGHT_ANGLE_OUT;
      default:             res.flip_angle = zr[22:8];
    endcase
  end

  assign push      = en && co_st[dfa_pkg::CORDIC_STEPS].tag.valid;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = buf0_r;

  always_comb begin
    buf0_nxt = buf0_r;
    buf1_nxt = buf1_r;
    cnt_nxt  = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          buf0_nxt = res;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          buf0_nxt = res;
        end else if (push) begin
          buf1_nxt = res;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          buf0_nxt = buf1_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      buf0_r <= buf0_nxt;
      buf1_r <= buf1_nxt;
    end
  end

  `ASSERT_IMPL(a_fid_zero_right, out_valid && out_data.fid_zero, out_data.flip_angle == dfa_pkg::RIGHT_ANGLE_OUT)
  `ASSERT_IMPL(a_angle_max, out_valid, out_data.flip_angle <= dfa_pkg::RIGHT_ANGLE_OUT)
  `ASSERT_NEXT(a_full_holds, (cnt_r == 2'd2) && !out_ready, (cnt_r == 2'd2) && $stable(buf1_r))

endmodule
`default_nettype wire
